/* rtl/core/lgs_pkg.sv */
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int CFG_W        = 11;
  localparam int FIELD_W      = 11;
  localparam int GRID_RESET   = 1024;
  localparam int MAX_SIZE_DEF = 1024;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = 2;
  localparam int FIFO_CNT_W   = 3;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] cell_col;
    logic [FIELD_W-1:0] cell_row;
    logic               next_alive;
    logic               frame_last;
  } result_t;

endpackage

/* rtl/core/lgs_ram.sv */
`timescale 1ns / 1ps

module lgs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1026
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lgs_window.sv */
`timescale 1ns / 1ps

module lgs_window #(
  parameter int POS_W = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                cell_i,
  input  logic [POS_W-1:0]    row_i,
  input  logic [POS_W-1:0]    col_i,
  input  logic [POS_W-1:0]    last_i,
  input  logic [1:0]          line_i,   // [0] upper line, [1] middle line
  output logic [1:0]          line_wdata_o,
  output logic                res_valid_o,
  output lgs_pkg::result_t    res_o
);

  localparam int EXT_W = (POS_W > lgs_pkg::FIELD_W) ? POS_W : lgs_pkg::FIELD_W;

  logic [8:0]       window_q, window_d;
  logic [2:0]       column;
  logic [3:0]       total;
  logic [3:0]       neigh;
  logic             centre;
  logic [EXT_W-1:0] row_ext, col_ext;

  assign column = {cell_i, line_i[1], line_i[0]};
  assign window_d = {column, window_q[8:3]};
  assign line_wdata_o = {cell_i, line_i[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (valid_i) begin
      window_q <= window_d;
    end
  end

  always_comb begin
    total = '0;
    for (int k = 0; k < 9; k++) begin
      total = total + {3'b000, window_d[k]};
    end
  end

  assign centre  = window_d[4];
  assign neigh   = total - {3'b000, centre};
  assign row_ext = EXT_W'(row_i - POS_W'(1));
  assign col_ext = EXT_W'(col_i - POS_W'(1));

  assign res_valid_o = valid_i && (row_i >= POS_W'(2)) && (col_i >= POS_W'(2));

  always_comb begin
    res_o.cell_row   = row_ext[lgs_pkg::FIELD_W-1:0];
    res_o.cell_col   = col_ext[lgs_pkg::FIELD_W-1:0];
    res_o.frame_last = (row_i == last_i) && (col_i == last_i);
    res_o.next_alive = (neigh == lgs_pkg::BIRTH_COUNT) ||
                       (centre && (neigh == lgs_pkg::SURVIVE_COUNT));
  end

endmodule

/* rtl/core/lgs_out_fifo.sv */
`timescale 1ns / 1ps

module lgs_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  lgs_pkg::result_t                    push_data_i,
  input  logic                                pop_i,
  output logic                                valid_o,
  output lgs_pkg::result_t                    data_o,
  output logic [lgs_pkg::FIFO_CNT_W-1:0]      count_o
);

  lgs_pkg::result_t                  buf_q [lgs_pkg::FIFO_DEPTH];
  logic [lgs_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [lgs_pkg::FIFO_CNT_W-1:0]    count_q, count_d;

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* rtl/core/life_generation_stencil.sv */
`timescale 1ns / 1ps
// Channel   | Dir | Handshake                    | Content
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | one cell of the bordered grid
// m_axis    | out | m_axis_tvalid/m_axis_tready  | next state of one interior cell
// cfg       | in  | cfg_valid_i/cfg_ready_o      | grid_size, restarts the frame
//
// One cell item per cycle sustained. An item is registered with its line buffer
// read, then window update and rule evaluation land in a 4-entry result queue:
// m_axis_tvalid is the queue's non-empty flag, so it follows the queue write. Input
// stalls only when the queue plus the in-flight item would overflow. Reset
// clears position, window and queue; line buffer contents are not cleared.

module life_generation_stencil #(
  parameter int MAX_SIZE = lgs_pkg::MAX_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lgs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [0] cell_alive
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lgs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [0] next_alive,
                                                           // [11:1] cell_row,
                                                           // [22:12] cell_col
  output logic                              m_axis_tlast,  // frame_last
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lgs_pkg::CFG_W-1:0]         cfg_data_i     // grid_size
);

  localparam int LINE_DEPTH = MAX_SIZE + 2;
  localparam int POS_W      = $clog2(LINE_DEPTH);
  localparam int EXT_W      = (POS_W > lgs_pkg::CFG_W) ? POS_W : lgs_pkg::CFG_W;
  localparam int RST_SIZE   = (lgs_pkg::GRID_RESET > MAX_SIZE) ? MAX_SIZE
                                                               : lgs_pkg::GRID_RESET;

  logic                 in_acc, cfg_acc;
  logic [POS_W-1:0]     row_q, row_d, col_q, col_d;
  logic [POS_W-1:0]     last_q, last_d;
  logic [EXT_W-1:0]     cfg_ext, size_sel;

  logic                 a_valid_q;
  logic                 a_cell_q;
  logic [POS_W-1:0]     a_row_q, a_col_q;

  logic [1:0]           line_rdata, line_wdata;
  logic                 res_valid;
  lgs_pkg::result_t     res, out_res;
  logic                 out_valid, out_pop;
  logic [lgs_pkg::FIFO_CNT_W-1:0] out_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = ({1'b0, out_count} + {{lgs_pkg::FIFO_CNT_W{1'b0}}, a_valid_q})
                         < (lgs_pkg::FIFO_CNT_W + 1)'(lgs_pkg::FIFO_DEPTH);

  // effective size: zero reads as one, clamp at MAX_SIZE
  always_comb begin
    cfg_ext = EXT_W'(cfg_data_i);
    if (cfg_ext == '0) begin
      size_sel = EXT_W'(1);
    end else if (cfg_ext > EXT_W'(MAX_SIZE)) begin
      size_sel = EXT_W'(MAX_SIZE);
    end else begin
      size_sel = cfg_ext;
    end
    last_d = size_sel[POS_W-1:0] + POS_W'(1);
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_acc) begin
      row_d = '0;
      col_d = '0;
    end else if (in_acc) begin
      if (col_q >= last_q) begin
        col_d = '0;
        row_d = (row_q >= last_q) ? '0 : row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      last_q    <= POS_W'(RST_SIZE + 1);
      a_valid_q <= 1'b0;
    end else begin
      row_q     <= row_d;
      col_q     <= col_d;
      a_valid_q <= in_acc;
      if (cfg_acc) begin
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cell_q <= s_axis_tdata[0];
      a_row_q  <= row_q;
      a_col_q  <= col_q;
    end
  end

  lgs_ram #(
    .WIDTH (2),
    .DEPTH (LINE_DEPTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (a_valid_q),
    .waddr_i (a_col_q),
    .wdata_i (line_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  lgs_window #(
    .POS_W (POS_W)
  ) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (a_valid_q),
    .cell_i       (a_cell_q),
    .row_i        (a_row_q),
    .col_i        (a_col_q),
    .last_i       (last_q),
    .line_i       (line_rdata),
    .line_wdata_o (line_wdata),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_pop = out_valid && m_axis_tready;

  lgs_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (out_pop),
    .valid_o     (out_valid),
    .data_o      (out_res),
    .count_o     (out_count)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.frame_last;
  assign m_axis_tdata  = {1'b0, out_res.cell_col, out_res.cell_row, out_res.next_alive};

endmodule

/* rtl/core/lgs_checker.sv */
`timescale 1ns / 1ps

module lgs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lgs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic                              m_axis_tlast
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // last cell of the frame sits on the diagonal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[11:1] == m_axis_tdata[22:12]))
    else $error("frame end off the diagonal");

  // a rising m_axis_tvalid always traces back to an accepted input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without input item");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
